/* hdl/quantile_group_selector_assert.svh */
// ----------------------------------------------------------------------------
// quantile group selector assertion macros
// shorthand for clocked checks on the top level
// ----------------------------------------------------------------------------
`ifndef QUANTILE_GROUP_SELECTOR_ASSERT_SVH
`define QUANTILE_GROUP_SELECTOR_ASSERT_SVH

// condition implies a property in the same cycle
`define QGS_ASSERT_SAME(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// condition implies a property in the next cycle
`define QGS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* hdl/qgs_pkg.sv */
// ----------------------------------------------------------------------------
// qgs_pkg
// types and constants shared by the quantile group selector
// ----------------------------------------------------------------------------
`default_nettype none

package qgs_pkg;

    localparam int MAX_IND   = 1024;
    localparam int IDX_W     = $clog2(MAX_IND);
    localparam int CNT_W     = IDX_W + 1;
    localparam int WORD_W    = IDX_W - 6;
    localparam int VAL_W     = 32;
    localparam int KEY_W     = VAL_W + IDX_W;
    localparam int BIT_W     = $clog2(KEY_W);
    localparam int Q_W       = 7;
    localparam int CFG_IDX_W = 2;
    localparam int MEM_W     = VAL_W + 1;

    localparam logic [VAL_W-1:0] NO_ANSWER  = 32'hFFFF_0000;
    localparam logic [Q_W-1:0]   QCNT_RESET = 7'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QIDX = 2'd0,
        CFG_QCNT = 2'd1
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_COUNT,
        ST_DIV_GO,
        ST_DIV,
        ST_MUL,
        ST_FIRST,
        ST_LAST,
        ST_SEARCH,
        ST_MASK,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

/* hdl/qgs_channels.sv */
// ----------------------------------------------------------------------------
// qgs channels
// valid/ready interfaces for input items, result words and register writes
// ----------------------------------------------------------------------------
`default_nettype none

interface qgs_in_if;
    logic                          valid;
    logic                          ready;
    logic [qgs_pkg::IDX_W-1:0]     individual;
    logic                          in_base;
    logic signed [qgs_pkg::VAL_W-1:0] contribution;
    logic                          end_of_data;

    modport source (output valid, individual, in_base, contribution, end_of_data,
                    input ready);
    modport sink (input valid, individual, in_base, contribution, end_of_data,
                  output ready);
endinterface

interface qgs_out_if;
    logic                             valid;
    logic                             ready;
    logic [qgs_pkg::WORD_W-1:0]       word_index;
    logic [63:0]                      mask_word;
    logic signed [qgs_pkg::VAL_W-1:0] min_bound;
    logic signed [qgs_pkg::VAL_W-1:0] max_bound;
    logic                             any_selected;
    logic                             last_word;

    modport source (output valid, word_index, mask_word, min_bound, max_bound,
                    any_selected, last_word, input ready);
    modport sink (input valid, word_index, mask_word, min_bound, max_bound,
                  any_selected, last_word, output ready);
endinterface

interface qgs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [qgs_pkg::CFG_IDX_W-1:0] index;
    logic [qgs_pkg::Q_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hdl/qgs_ram.sv */
// ----------------------------------------------------------------------------
// qgs_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module qgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hdl/qgs_div.sv */
// ----------------------------------------------------------------------------
// qgs_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module qgs_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [qgs_pkg::CNT_W-1:0] i_dividend,
    input  wire logic [qgs_pkg::Q_W-1:0]   i_divisor,
    output logic                           o_done,
    output logic      [qgs_pkg::CNT_W-1:0] o_quo,
    output logic      [qgs_pkg::Q_W-1:0]   o_rem
);
    import qgs_pkg::*;

    localparam int STEP_W = $clog2(CNT_W + 1);

    logic [CNT_W-1:0]  r_quo, n_quo;
    logic [Q_W-1:0]    r_rem, n_rem;
    logic [Q_W-1:0]    r_dvs;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [Q_W:0]      trial;

    always_comb begin
        trial  = {r_rem, r_quo[CNT_W-1]};
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_step = r_step;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_quo  = i_dividend;
            n_rem  = '0;
            n_step = STEP_W'(CNT_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = Q_W'(trial - {1'b0, r_dvs});
                n_quo = {r_quo[CNT_W-2:0], 1'b1};
            end else begin
                n_rem = trial[Q_W-1:0];
                n_quo = {r_quo[CNT_W-2:0], 1'b0};
            end
            n_step = r_step - 1'b1;
            if (r_step == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

/* hdl/quantile_group_selector.sv */
// ----------------------------------------------------------------------------
// quantile_group_selector
// ranks base members by value and emits the selection mask of one quantile
// ----------------------------------------------------------------------------
// The stored value of an ordinary item is read as the item is taken and then
// written back. After reset, and again after every end item, the value store
// is swept back to the no-answer mark, all 1024 entries with the input not
// ready. An end item loads, then runs one counting sweep, a divide, then 42
// search sweeps that pin the ordering keys (value, index) of the first and
// last rank of the group one key bit per sweep over the single memory read
// port, then a mask sweep that emits one 64-bit word every 64 entries,
// waiting on the output when it is held, and finally the clearing sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module quantile_group_selector (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    qgs_in_if.sink    i_in,
    qgs_out_if.source o_out,
    qgs_cfg_if.sink   i_cfg
);
    import qgs_pkg::*;

    t_state r_state, n_state;

    logic [CNT_W-1:0] r_addr, n_addr;
    logic             r_dv, n_dv;
    logic [IDX_W-1:0] r_didx, n_didx;
    logic [CNT_W-1:0] r_n, n_n, r_neg, n_neg;
    logic [CNT_W-1:0] r_cnt_lo, n_cnt_lo, r_cnt_hi, n_cnt_hi;
    logic [CNT_W-1:0] r_first, n_first, r_last, n_last, r_prod, n_prod;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic [KEY_W-1:0] r_klo, n_klo, r_khi, n_khi;
    logic [63:0]      r_word, n_word;
    logic [Q_W-1:0]   r_qidx, r_qcnt;

    logic [IDX_W-1:0] r_ind;
    logic             r_base, r_end;
    logic [VAL_W-1:0] r_contr;

    logic             r_o_valid, n_o_valid;
    logic             r_o_load;
    logic [WORD_W-1:0] r_o_widx;
    logic [63:0]      r_o_mask;
    logic [VAL_W-1:0] r_o_lo, r_o_hi;
    logic             r_o_any, r_o_last;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    logic [MEM_W-1:0] mem_wdata, mem_rdata;

    logic             div_start, div_done;
    logic [CNT_W-1:0] div_quo;
    logic [Q_W-1:0]   div_rem;

    logic             in_acc, issue, pass_end, any;
    logic             d_flag;
    logic [VAL_W-1:0] d_val, new_val;
    logic [VAL_W-1:0] sum;
    logic [KEY_W-1:0] d_key, cand_lo, cand_hi;
    logic [Q_W-1:0]   qm1;
    logic [CNT_W-1:0] extra;
    logic [CNT_W-1:0] prod_full;

    qgs_ram #(.WIDTH(MEM_W), .DEPTH(MAX_IND)) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    qgs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_n - r_neg),
        .i_divisor  (r_qcnt),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && i_in.ready;

    assign d_flag = mem_rdata[VAL_W];
    assign d_val  = mem_rdata[VAL_W-1:0];
    assign d_key  = {~d_val[VAL_W-1], d_val[VAL_W-2:0], r_didx};
    assign cand_lo = r_klo & ~(KEY_W'(1) << r_bit);
    assign cand_hi = r_khi & ~(KEY_W'(1) << r_bit);
    assign any     = r_first < r_last;
    assign qm1     = r_qidx - 1'b1;
    // product never exceeds the respondent count when the group is in range
    assign prod_full = CNT_W'(qm1) * div_quo;

    // load: saturating add onto an answered value, replace the no-answer mark
    always_comb begin
        // both operands are non-negative where the sum is used
        sum     = d_val + r_contr;
        new_val = d_val;
        if (!r_contr[VAL_W-1]) begin
            if (!d_val[VAL_W-1]) begin
                new_val = sum[VAL_W-1] ? {1'b0, {(VAL_W-1){1'b1}}} : sum;
            end else begin
                new_val = r_contr;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_dv      = 1'b0;
        n_didx    = r_didx;
        n_n       = r_n;
        n_neg     = r_neg;
        n_cnt_lo  = r_cnt_lo;
        n_cnt_hi  = r_cnt_hi;
        n_first   = r_first;
        n_last    = r_last;
        n_prod    = r_prod;
        n_bit     = r_bit;
        n_klo     = r_klo;
        n_khi     = r_khi;
        n_word    = r_word;
        mem_we    = 1'b0;
        mem_waddr = r_addr[IDX_W-1:0];
        mem_wdata = {1'b0, NO_ANSWER};
        mem_raddr = r_addr[IDX_W-1:0];
        div_start = 1'b0;
        n_o_valid = r_o_valid && !o_out.ready;
        extra     = '0;
        issue     = 1'b0;
        pass_end  = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == CNT_W'(MAX_IND - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                mem_raddr = i_in.individual;
                if (in_acc) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                mem_we    = 1'b1;
                mem_waddr = r_ind;
                mem_wdata = {d_flag | r_base, new_val};
                n_addr    = '0;
                n_n       = '0;
                n_neg     = '0;
                n_state   = r_end ? ST_COUNT : ST_IDLE;
            end
            ST_COUNT, ST_SEARCH: begin
                issue    = r_addr < CNT_W'(MAX_IND);
                pass_end = !issue && !r_dv;
                n_dv     = issue;
                n_didx   = r_addr[IDX_W-1:0];
                if (issue) begin
                    n_addr = r_addr + 1'b1;
                end
                if (r_dv && d_flag) begin
                    n_n      = r_n + 1'b1;
                    n_neg    = r_neg + CNT_W'(d_val[VAL_W-1]);
                    n_cnt_lo = r_cnt_lo + CNT_W'(d_key <= cand_lo);
                    n_cnt_hi = r_cnt_hi + CNT_W'(d_key <= cand_hi);
                end
                if (r_state == ST_SEARCH) begin
                    n_n   = r_n;
                    n_neg = r_neg;
                end
                if (pass_end) begin
                    n_addr   = '0;
                    n_cnt_lo = '0;
                    n_cnt_hi = '0;
                    if (r_state == ST_COUNT) begin
                        n_state = ST_DIV_GO;
                    end else begin
                        // keep the cleared bit when enough keys sit at or below
                        if (r_cnt_lo > r_first) begin
                            n_klo = cand_lo;
                        end
                        if (r_cnt_hi >= r_last) begin
                            n_khi = cand_hi;
                        end
                        n_bit = r_bit - 1'b1;
                        if (r_bit == '0) begin
                            n_state = ST_MASK;
                            n_word  = '0;
                        end
                    end
                end
            end
            ST_DIV_GO: begin
                div_start = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_prod  = prod_full;
                n_state = ST_FIRST;
            end
            ST_FIRST: begin
                if (r_qidx == '0) begin
                    n_first = '0;
                end else if (r_qidx <= r_qcnt) begin
                    extra   = (qm1 < div_rem) ? CNT_W'(qm1) : CNT_W'(div_rem);
                    n_first = r_neg + r_prod + extra;
                end else begin
                    n_first = r_neg;
                end
                n_state = ST_LAST;
            end
            ST_LAST: begin
                if (r_qidx == '0) begin
                    n_last = r_neg;
                end else if (r_qidx <= r_qcnt) begin
                    n_last = r_first + div_quo + CNT_W'(qm1 < div_rem);
                end else begin
                    n_last = r_first;
                end
                n_klo    = '1;
                n_khi    = '1;
                n_bit    = BIT_W'(KEY_W - 1);
                n_addr   = '0;
                n_cnt_lo = '0;
                n_cnt_hi = '0;
                n_state  = ST_SEARCH;
            end
            ST_MASK: begin
                // one read, then one compare, per entry
                if (!r_dv) begin
                    n_dv   = 1'b1;
                    n_didx = r_addr[IDX_W-1:0];
                    n_addr = r_addr + 1'b1;
                end else begin
                    if (any && d_flag && d_key >= r_klo && d_key <= r_khi) begin
                        n_word = r_word | (64'd1 << r_didx[5:0]);
                    end
                    if (r_didx[5:0] == 6'h3F) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (!r_o_valid || o_out.ready) begin
                    n_o_valid = 1'b1;
                    n_word    = '0;
                    if (r_didx[IDX_W-1:6] == '1) begin
                        n_addr  = '0;
                        n_state = ST_CLEAR;
                    end else begin
                        n_state = ST_MASK;
                    end
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_addr    <= '0;
            r_dv      <= 1'b0;
            r_o_valid <= 1'b0;
            r_o_load  <= 1'b0;
            r_qidx    <= '0;
            r_qcnt    <= QCNT_RESET;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_dv      <= n_dv;
            r_o_valid <= n_o_valid;
            r_o_load  <= (r_state == ST_EMIT) && (!r_o_valid || o_out.ready);
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    CFG_QIDX: r_qidx <= i_cfg.data;
                    CFG_QCNT: r_qcnt <= i_cfg.data;
                    default: ;
                endcase
            end
        end
        r_didx   <= n_didx;
        r_n      <= n_n;
        r_neg    <= n_neg;
        r_cnt_lo <= n_cnt_lo;
        r_cnt_hi <= n_cnt_hi;
        r_first  <= n_first;
        r_last   <= n_last;
        r_prod   <= n_prod;
        r_bit    <= n_bit;
        r_klo    <= n_klo;
        r_khi    <= n_khi;
        r_word   <= n_word;
        if (in_acc) begin
            r_ind   <= i_in.individual;
            r_base  <= i_in.in_base;
            r_contr <= i_in.contribution;
            r_end   <= i_in.end_of_data;
        end
        if (r_state == ST_EMIT && (!r_o_valid || o_out.ready)) begin
            r_o_widx <= r_didx[IDX_W-1:6];
            r_o_mask <= r_word;
            r_o_lo   <= any ? {~r_klo[KEY_W-1], r_klo[KEY_W-2:IDX_W]} : '0;
            r_o_hi   <= any ? {~r_khi[KEY_W-1], r_khi[KEY_W-2:IDX_W]} : '0;
            r_o_any  <= any;
            r_o_last <= (r_didx[IDX_W-1:6] == '1);
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.word_index   = r_o_widx;
    assign o_out.mask_word    = r_o_mask;
    assign o_out.min_bound    = r_o_lo;
    assign o_out.max_bound    = r_o_hi;
    assign o_out.any_selected = r_o_any;
    assign o_out.last_word    = r_o_last;

`include "quantile_group_selector_assert.svh"

    `QGS_ASSERT_SAME(a_bounds_order, o_out.valid && o_out.any_selected, $signed(o_out.min_bound) <= $signed(o_out.max_bound), "bounds out of order")
    `QGS_ASSERT_SAME(a_empty_word, o_out.valid && !o_out.any_selected, o_out.mask_word == 64'd0 && o_out.min_bound == 0 && o_out.max_bound == 0, "empty group with bits or bounds")
    `QGS_ASSERT_SAME(a_fresh_word, r_o_load, o_out.valid, "loaded word not shown")

endmodule

`default_nettype wire
